@@ sv/global_average_pool_macros.svh @@
// assertion helpers shared by the block
`ifndef GLOBAL_AVERAGE_POOL_MACROS_SVH
`define GLOBAL_AVERAGE_POOL_MACROS_SVH

// checked on every clock edge outside reset
`define GAP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define GAP_ASSERT_ANY_CYCLE(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/gap_pkg.sv @@
package gap_pkg;

   // configuration port
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 9;
   localparam int SIDE_REG_BITS = 9;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_MAP_HEIGHT = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MAP_WIDTH  = 2'd1;

   // controller states
   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DIVIDE,
      ST_FINISH
   } gap_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic accum;
      logic start_div;
      logic step_div;
      logic load_out;
   } gap_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last_sample;
      logic div_done;
   } gap_status_type;

endpackage

@@ sv/gap_req_if.sv @@
interface gap_req_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

@@ sv/gap_rsp_if.sv @@
interface gap_rsp_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] channel_mean;

   modport source (output valid, output channel_mean, input ready);
   modport sink   (input valid, input channel_mean, output ready);
endinterface

@@ sv/gap_csr_if.sv @@
interface gap_csr_if import gap_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_ADDR_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ sv/gap_dpath.sv @@
module gap_dpath import gap_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_SIDE    = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [CSR_ADDR_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  gap_cmd_type                   cmd,
   output gap_status_type                status,
   output logic signed [SAMPLE_BITS-1:0] channel_mean
);

   localparam int SIDE_BITS = $clog2(MAX_SIDE + 1);
   localparam int CNT_BITS  = $clog2(MAX_SIDE * MAX_SIDE + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + 2 * $clog2(MAX_SIDE);
   localparam int STEP_BITS = $clog2(SUM_BITS);
   localparam int CMP_BITS  = (SIDE_REG_BITS > SIDE_BITS) ? SIDE_REG_BITS : SIDE_BITS;

   // zero counts as one, anything above the largest side as the largest side
   function automatic logic [SIDE_BITS-1:0] clamp_side(input logic [SIDE_REG_BITS-1:0] v);
      logic [CMP_BITS-1:0] wide;
      wide = CMP_BITS'(v);
      if (v == '0) begin
         return SIDE_BITS'(1);
      end else if (wide > CMP_BITS'(MAX_SIDE)) begin
         return SIDE_BITS'(MAX_SIDE);
      end else begin
         return SIDE_BITS'(v);
      end
   endfunction

   logic [SIDE_REG_BITS-1:0] map_height_ff, map_height_in;
   logic [SIDE_REG_BITS-1:0] map_width_ff, map_width_in;
   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [SUM_BITS-1:0]      quo_ff, quo_in;
   logic [CNT_BITS-1:0]      rem_ff, rem_in;
   logic [CNT_BITS-1:0]      divisor_ff, divisor_in;
   logic                     neg_ff, neg_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [SAMPLE_BITS-1:0]   mean_ff, mean_in;

   logic [SIDE_BITS-1:0]     height_side;
   logic [SIDE_BITS-1:0]     width_side;
   logic [2*SIDE_BITS-1:0]   target_full;
   logic [CNT_BITS-1:0]      target;
   logic [CNT_BITS-1:0]      count_next;
   logic [SUM_BITS-1:0]      sample_ext;
   logic [SUM_BITS-1:0]      sum_next;
   logic [SUM_BITS-1:0]      sum_mag;
   logic [CNT_BITS:0]        shifted;
   logic                     fits;
   logic [SAMPLE_BITS-1:0]   quo_low;

   // configuration registers
   always_comb begin
      map_height_in = map_height_ff;
      map_width_in  = map_width_ff;
      if (csr_valid) begin
         if (csr_index == CSR_MAP_HEIGHT) begin
            map_height_in = SIDE_REG_BITS'(csr_wdata);
         end else if (csr_index == CSR_MAP_WIDTH) begin
            map_width_in = SIDE_REG_BITS'(csr_wdata);
         end
      end
   end

   // samples per channel from the current registers
   always_comb begin
      height_side = clamp_side(map_height_ff);
      width_side  = clamp_side(map_width_ff);
      target_full = {{SIDE_BITS{1'b0}}, height_side} * {{SIDE_BITS{1'b0}}, width_side};
      target      = target_full[CNT_BITS-1:0];
   end

   // running sum and count
   always_comb begin
      sample_ext  = SUM_BITS'(sample);
      sum_next    = sum_ff + sample_ext;
      count_next  = count_ff + CNT_BITS'(1);
      sum_mag     = sum_next[SUM_BITS-1] ? (-sum_next) : sum_next;
      sum_in      = sum_ff;
      count_in    = count_ff;
      if (cmd.start_div) begin
         sum_in   = '0;
         count_in = '0;
      end else if (cmd.accum) begin
         sum_in   = sum_next;
         count_in = count_next;
      end
   end

   // restoring divider on the sum magnitude, one quotient bit a cycle
   always_comb begin
      shifted    = {rem_ff, quo_ff[SUM_BITS-1]};
      fits       = shifted >= {1'b0, divisor_ff};
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      step_in    = step_ff;
      if (cmd.start_div) begin
         quo_in     = sum_mag;
         rem_in     = '0;
         divisor_in = target;
         neg_in     = sum_next[SUM_BITS-1];
         step_in    = '0;
      end else if (cmd.step_div) begin
         quo_in  = {quo_ff[SUM_BITS-2:0], fits};
         rem_in  = fits ? CNT_BITS'(shifted - {1'b0, divisor_ff}) : shifted[CNT_BITS-1:0];
         step_in = step_ff + STEP_BITS'(1);
      end
   end

   // signed mean into the output register
   always_comb begin
      quo_low = quo_ff[SAMPLE_BITS-1:0];
      mean_in = mean_ff;
      if (cmd.load_out) begin
         mean_in = neg_ff ? (-quo_low) : quo_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_height_ff <= SIDE_REG_BITS'(1);
         map_width_ff  <= SIDE_REG_BITS'(1);
         sum_ff        <= '0;
         count_ff      <= '0;
      end else begin
         map_height_ff <= map_height_in;
         map_width_ff  <= map_width_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
      step_ff    <= step_in;
      mean_ff    <= mean_in;
   end

   assign status.last_sample = count_next >= target;
   assign status.div_done    = step_ff == STEP_BITS'(SUM_BITS - 1);
   assign channel_mean       = mean_ff;

endmodule

@@ sv/gap_ctrl.sv @@
`include "global_average_pool_macros.svh"

module gap_ctrl import gap_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  gap_status_type status,
   output gap_cmd_type    cmd
);

   gap_state_type state_ff, state_in;
   logic          out_full_ff, out_full_in;
   logic          req_fire;
   logic          out_free;

   assign req_ready = state_ff == ST_ACCUM;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !out_full_ff || rsp_ready;
   assign rsp_valid = out_full_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (req_fire && status.last_sample) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_ACCUM: begin
            cmd.accum     = req_fire;
            cmd.start_div = req_fire && status.last_sample;
         end
         ST_DIVIDE: begin
            cmd.step_div = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_out = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // output register occupancy
   always_comb begin
      out_full_in = out_full_ff;
      if (cmd.load_out) begin
         out_full_in = 1'b1;
      end else if (rsp_ready) begin
         out_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_ACCUM;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_full_ff <= out_full_in;
      end
   end

   // checks
   `GAP_ASSERT_ANY_CYCLE(a_reset_idle, reset |=> (state_ff == ST_ACCUM && !out_full_ff), "block not idle after reset")
   `GAP_ASSERT(a_last_starts_div, (req_fire && status.last_sample) |=> (state_ff == ST_DIVIDE), "channel end did not start the divider")
   `GAP_ASSERT(a_div_holds, (state_ff == ST_DIVIDE && !status.div_done) |=> (state_ff == ST_DIVIDE), "divider left before its last step")
   `GAP_ASSERT(a_no_overwrite, cmd.load_out |-> (!out_full_ff || rsp_ready), "pending mean overwritten")
   `GAP_ASSERT(a_full_from_finish, $rose(out_full_ff) |-> $past(state_ff == ST_FINISH), "output filled outside the finish state")

endmodule

@@ sv/global_average_pool.sv @@
// Global average pooling. Samples (signed Q8.8) arrive one per transaction, channel after
// channel, each channel's map in row-major order; after map_height*map_width samples the
// block returns one transaction holding that channel's mean, truncated toward zero. A side
// register written as 0 acts as 1 and one above MAX_SIDE acts as MAX_SIDE; a write in the
// middle of a channel keeps the partial sum and takes effect from the next sample. Samples are
// taken one per cycle while the block accumulates; the sample that closes a channel starts
// a restoring divider that yields one quotient bit per cycle over the SAMPLE_BITS +
// 2*clog2(MAX_SIDE) bit sum, then the output register is loaded once it is free; no sample
// is taken until then. The mean waits in an output register, so the next channel streams
// in while it is unclaimed.
module global_average_pool import gap_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_SIDE    = 256
) (
   input logic clock,
   input logic reset,
   gap_req_if.sink   req_bus,
   gap_rsp_if.source rsp_bus,
   gap_csr_if.sink   csr_bus
);

   gap_cmd_type    cmd;
   gap_status_type status;

   // registers are always writable
   assign csr_bus.ready = 1'b1;

   // sequencer
   gap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // accumulator, divider and output register
   gap_dpath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_SIDE    (MAX_SIDE)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_bus.valid),
      .csr_index    (csr_bus.index),
      .csr_wdata    (csr_bus.wdata),
      .sample       (req_bus.sample),
      .cmd          (cmd),
      .status       (status),
      .channel_mean (rsp_bus.channel_mean)
   );

endmodule

@@ dv/tb_global_average_pool.sv @@
module tb_global_average_pool import gap_pkg::*; ();

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_SIDE    = 256;

   // divider walks one quotient bit per cycle, then loads the output
   localparam int DIVIDE_CYCLES = SAMPLE_BITS + 2 * $clog2(MAX_SIDE) + 1;
   localparam int SETTLE_CYCLES = 2 * DIVIDE_CYCLES + 8;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int MAX_REPORTS   = 10;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // register indexes that map to nothing
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_HI = 2'd3;

   logic clock;
   logic reset;

   gap_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   gap_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();
   gap_csr_if csr_bus ();

   global_average_pool #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAX_SIDE   (MAX_SIDE)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // pooling predictor state
   logic [SIDE_REG_BITS-1:0] cfg_height;
   logic [SIDE_REG_BITS-1:0] cfg_width;
   longint                   channel_sum;
   longint                   channel_count;

   logic signed [SAMPLE_BITS-1:0] expected_means[$];
   logic signed [SAMPLE_BITS-1:0] oldest_mean;

   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles_left;
   int failure_count;
   int cycle_count;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic void report_failure(input string msg);
      failure_count++;
      if (failure_count <= MAX_REPORTS) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
   endfunction

   // a side register of 0 acts as 1, above the maximum acts as the maximum
   function automatic longint effective_side(input logic [SIDE_REG_BITS-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_SIDE) return MAX_SIDE;
      return longint'(raw);
   endfunction

   // add one sample; a closed channel queues its truncated mean
   function automatic void accumulate_sample(input logic signed [SAMPLE_BITS-1:0] value);
      longint target;
      longint mean;
      target = effective_side(cfg_height) * effective_side(cfg_width);
      channel_sum += value;
      channel_count++;
      if (channel_count >= target) begin
         mean = channel_sum / target;
         expected_means.push_back(mean[SAMPLE_BITS-1:0]);
         channel_sum   = 0;
         channel_count = 0;
      end
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return SAMPLE_BITS'($signed($urandom_range(8)) - 4);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [SIDE_REG_BITS-1:0] random_side();
      case ($urandom_range(9))
         7: return '0;
         8: return SIDE_REG_BITS'($urandom_range(5, 511));
         9: return ($urandom_range(1) != 0) ? 9'h1FF : 9'd256;
         default: return SIDE_REG_BITS'($urandom_range(1, 4));
      endcase
   endfunction

   // offer one sample transaction; valid stays high until the next call decides
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= value;
      do @(posedge clock); while (!req_bus.ready);
      accumulate_sample(value);
   endtask

   // one register write transaction; the last of a group lowers valid
   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value, input bit last);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.wdata <= value;
      do @(posedge clock); while (!csr_bus.ready);
      if (index == CSR_MAP_HEIGHT) begin
         cfg_height = value;
      end else if (index == CSR_MAP_WIDTH) begin
         cfg_width = value;
      end
      if (last) begin
         @(negedge clock);
         csr_bus.valid <= 1'b0;
      end
   endtask

   // stop offering, let every mean arrive, then let the divider settle
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_means.size() == 0) begin
            report_failure($sformatf("unexpected channel_mean %0d",
                                     $signed(rsp_bus.channel_mean)));
         end else begin
            oldest_mean = expected_means.pop_front();
            if (rsp_bus.channel_mean !== oldest_mean) begin
               report_failure($sformatf("channel_mean expected %0d got %0d",
                                        oldest_mean, $signed(rsp_bus.channel_mean)));
            end
         end
      end
   end

   // result receiver, with an optional long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // one sample per channel at the reset map size, extreme values
   task automatic test_unit_map();
      send_sample('0);
      send_sample(16'sd1);
      send_sample(-16'sd1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(16'sh5555);
      wait_idle();
   endtask

   // three-sample channels whose means must truncate toward zero
   task automatic test_truncation();
      csr_write(CSR_MAP_HEIGHT, 9'd1, 1'b0);
      csr_write(CSR_MAP_WIDTH, 9'd3, 1'b1);
      send_sample(-16'sd1);
      send_sample(-16'sd1);
      send_sample('0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(16'shAAAA);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN + 16'sd1);
      wait_idle();
   endtask

   // zero sides act as one, spare indexes change nothing
   task automatic test_register_edges();
      csr_write(CSR_MAP_HEIGHT, '0, 1'b0);
      csr_write(CSR_MAP_WIDTH, '0, 1'b0);
      csr_write(CSR_SPARE_LO, 9'h1FF, 1'b0);
      csr_write(CSR_SPARE_HI, 9'h1FF, 1'b1);
      send_sample(16'sh1234);
      send_sample(-16'sd300);
      wait_idle();
   endtask

   // map size changes with a channel half summed
   task automatic test_mid_channel_write();
      csr_write(CSR_MAP_HEIGHT, 9'd2, 1'b0);
      csr_write(CSR_MAP_WIDTH, 9'd2, 1'b1);
      send_sample(16'sd700);
      send_sample(-16'sd100);
      wait_idle();
      // target shrinks to one above the count: next sample closes the channel
      csr_write(CSR_MAP_HEIGHT, 9'd3, 1'b0);
      csr_write(CSR_MAP_WIDTH, 9'd1, 1'b1);
      send_sample(16'sd5);
      wait_idle();
      csr_write(CSR_MAP_HEIGHT, 9'd4, 1'b0);
      csr_write(CSR_MAP_WIDTH, 9'd4, 1'b1);
      repeat (5) send_sample(SAMPLE_MAX);
      wait_idle();
      // target shrinks below the count: mean of more samples than the target
      csr_write(CSR_MAP_HEIGHT, 9'd1, 1'b0);
      csr_write(CSR_MAP_WIDTH, 9'd2, 1'b1);
      send_sample(SAMPLE_MAX);
      wait_idle();
   endtask

   // receiver holds off while samples keep coming, so the input stalls
   task automatic test_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(CSR_MAP_HEIGHT, 9'd1, 1'b0);
      csr_write(CSR_MAP_WIDTH, 9'd1, 1'b1);
      hold_cycles_left = 300;
      repeat (40) send_sample(random_sample());
      wait_idle();
   endtask

   // random map sizes, whole channels with the odd partial one left open
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int item_budget);
      int                       sent;
      int                       burst;
      longint                   target;
      logic [SIDE_REG_BITS-1:0] height;
      logic [SIDE_REG_BITS-1:0] width;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < item_budget) begin
         height = random_side();
         width  = random_side();
         if (effective_side(height) * effective_side(width) > 64) begin
            width = ($urandom_range(1) != 0) ? 9'd0 : 9'd1;
         end
         target = effective_side(height) * effective_side(width);
         wait_idle();
         if ($urandom_range(7) == 0) begin
            csr_write(($urandom_range(1) != 0) ? CSR_SPARE_LO : CSR_SPARE_HI,
                      CSR_DATA_BITS'($urandom), 1'b0);
         end
         csr_write(CSR_MAP_HEIGHT, height, 1'b0);
         csr_write(CSR_MAP_WIDTH, width, 1'b1);
         burst = int'(target) * ((target > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6));
         if ($urandom_range(3) == 0) begin
            burst += $urandom_range(0, int'(target) - 1);
         end
         repeat (burst) begin
            send_sample(random_sample());
            sent++;
         end
      end
      wait_idle();
   endtask

   // oversize side clamps to the largest side, most negative samples, then a full-width row
   task automatic test_largest_map();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // close any open partial channel at the unit map size
      csr_write(CSR_MAP_HEIGHT, 9'd1, 1'b0);
      csr_write(CSR_MAP_WIDTH, 9'd1, 1'b1);
      send_sample('0);
      wait_idle();
      csr_write(CSR_MAP_HEIGHT, 9'h1FF, 1'b0);
      csr_write(CSR_MAP_WIDTH, '0, 1'b1);
      repeat (MAX_SIDE) send_sample(SAMPLE_MIN);
      wait_idle();
      csr_write(CSR_MAP_HEIGHT, 9'd1, 1'b0);
      csr_write(CSR_MAP_WIDTH, 9'd256, 1'b1);
      repeat (MAX_SIDE) send_sample(random_sample());
      wait_idle();
   endtask

   // test sequence
   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.sample   = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.wdata    = '0;
      cfg_height       = 9'd1;
      cfg_width        = 9'd1;
      channel_sum      = 0;
      channel_count    = 0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      hold_cycles_left = 0;
      failure_count    = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unit_map();
      test_truncation();
      test_register_edges();
      test_mid_channel_write();
      test_output_stall();
      test_random_traffic(30, 67, 390);
      test_random_traffic(67, 30, 390);
      test_random_traffic(0, 0, 391);
      test_largest_map();

      wait_idle();
      if (failure_count == 0 && expected_means.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ global_average_pool.f @@
+incdir+sv
sv/gap_pkg.sv
sv/gap_req_if.sv
sv/gap_rsp_if.sv
sv/gap_csr_if.sv
sv/gap_dpath.sv
sv/gap_ctrl.sv
sv/global_average_pool.sv
dv/tb_global_average_pool.sv
